### rtl/fnrs_pkg.sv
// Shared types and constants for the font name record selector.
package fnrs_pkg;

    // Slot count and field widths
    localparam int NumSlots   = 4;
    localparam int FieldWidth = 16;

    // Name kinds that map to slots
    localparam logic [15:0] KIND_FAMILY      = 16'd1;
    localparam logic [15:0] KIND_STYLE       = 16'd2;
    localparam logic [15:0] KIND_PREF_FAMILY = 16'd16;
    localparam logic [15:0] KIND_PREF_STYLE  = 16'd17;

    // Platform and language codes
    localparam logic [15:0] PLAT_UNICODE = 16'd0;
    localparam logic [15:0] PLAT_ROMAN   = 16'd1;
    localparam logic [15:0] PLAT_WIDE    = 16'd3;
    localparam logic [15:0] LANG_MASK    = 16'h03ff;
    localparam logic [15:0] LANG_ENGLISH = 16'h0009;
    localparam logic [15:0] UNICODE_ENC_LIMIT = 16'd4;

    // Header geometry
    localparam logic [31:0] MIN_TABLE    = 32'd8;
    localparam logic [19:0] HEADER_BYTES = 20'd6;

    // Slot ranks
    typedef logic [1:0] rank_t;
    localparam rank_t RANK_NONE    = 2'd0;
    localparam rank_t RANK_UNICODE = 2'd1;
    localparam rank_t RANK_ROMAN   = 2'd2;
    localparam rank_t RANK_WIDE    = 2'd3;

    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_FAMILY      = 2'd0;
    localparam slot_t SLOT_STYLE       = 2'd1;
    localparam slot_t SLOT_PREF_FAMILY = 2'd2;
    localparam slot_t SLOT_PREF_STYLE  = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] REG_TABLE_BYTES   = 8'd0;
    localparam logic [7:0] REG_TABLE_VERSION = 8'd1;
    localparam logic [7:0] REG_RECORD_COUNT  = 8'd2;
    localparam logic [7:0] REG_STRING_BASE   = 8'd3;

    // Decision for one record beat
    typedef struct packed {
        logic  take;
        slot_t slot;
        rank_t rank;
    } rec_update_t;

    // One result held for the output drain
    typedef struct packed {
        logic        found;
        logic [15:0] record_index;
        logic        is_utf16;
        logic [16:0] text_start;
        logic [15:0] text_bytes;
    } result_t;

endpackage

### rtl/fnrs_record_eval.sv
// Ranks one name record against the slot it targets.
module fnrs_record_eval
(
    input  logic [15:0]                        plat_code,
    input  logic [15:0]                        enc_code,
    input  logic [15:0]                        lang_code,
    input  logic [15:0]                        name_kind,
    input  logic [15:0]                        text_length,
    input  logic [15:0]                        text_offset,
    input  logic [15:0]                        record_idx,
    input  logic [15:0]                        record_count,
    input  logic [15:0]                        string_base,
    input  logic [31:0]                        table_bytes,
    input  fnrs_pkg::rank_t [fnrs_pkg::NumSlots-1:0] slot_rank,
    output fnrs_pkg::rec_update_t              update
);

    logic            kind_ok;
    fnrs_pkg::slot_t slot;
    logic [17:0]     text_end;
    logic            in_bounds;
    logic            in_count;
    fnrs_pkg::rank_t cur;
    logic            wide_ok;
    logic            uni_ok;
    logic            roman_ok;

    // Map the name kind to a slot
    always_comb
    begin
        kind_ok = 1'b1;
        slot    = fnrs_pkg::SLOT_FAMILY;
        case (name_kind)
            fnrs_pkg::KIND_FAMILY:      slot = fnrs_pkg::SLOT_FAMILY;
            fnrs_pkg::KIND_STYLE:       slot = fnrs_pkg::SLOT_STYLE;
            fnrs_pkg::KIND_PREF_FAMILY: slot = fnrs_pkg::SLOT_PREF_FAMILY;
            fnrs_pkg::KIND_PREF_STYLE:  slot = fnrs_pkg::SLOT_PREF_STYLE;
            default:                    kind_ok = 1'b0;
        endcase
    end

    // Skip strings that run past the table end and records beyond the count
    assign text_end  = {2'b00, string_base} + {2'b00, text_offset} + {2'b00, text_length};
    assign in_bounds = ({14'd0, text_end} <= table_bytes);
    assign in_count  = (record_idx < record_count);

    assign cur = slot_rank[slot];

    // Platform rules, one per platform code
    assign wide_ok = (plat_code == fnrs_pkg::PLAT_WIDE)
                  && (enc_code == 16'd0 || enc_code == 16'd1)
                  && (((lang_code & fnrs_pkg::LANG_MASK) == fnrs_pkg::LANG_ENGLISH)
                      || (cur < fnrs_pkg::RANK_WIDE));
    assign uni_ok  = (plat_code == fnrs_pkg::PLAT_UNICODE)
                  && (enc_code < fnrs_pkg::UNICODE_ENC_LIMIT)
                  && (cur < fnrs_pkg::RANK_UNICODE);
    assign roman_ok = (plat_code == fnrs_pkg::PLAT_ROMAN)
                   && (enc_code == 16'd0) && (lang_code == 16'd0)
                   && (cur < fnrs_pkg::RANK_ROMAN);

    always_comb
    begin
        update.slot = slot;
        update.take = 1'b0;
        update.rank = fnrs_pkg::RANK_NONE;
        if (kind_ok && in_bounds && in_count)
        begin
            if (wide_ok)
            begin
                update.take = 1'b1;
                update.rank = fnrs_pkg::RANK_WIDE;
            end
            else if (uni_ok)
            begin
                update.take = 1'b1;
                update.rank = fnrs_pkg::RANK_UNICODE;
            end
            else if (roman_ok)
            begin
                update.take = 1'b1;
                update.rank = fnrs_pkg::RANK_ROMAN;
            end
        end
    end

endmodule

### rtl/font_name_record_selector.sv
// Top level of the font name record selector: slot state, result bank and drain.
// A record beat updates its slot at the accepting edge; a last beat captures the
// four results, the first shown the next cycle, one per cycle after while m_axis_tready is high.
// Throughput: one input beat per cycle; a last beat stalls only while the
// previous run's four results are still draining through the single result bank.
// Reset (rst_n low, async) clears all slot ranks, the record counter, config and bank valid.
module font_name_record_selector
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input record stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // platform[15:0], encoding[31:16], language[47:32], name_kind[63:48],
    // text_length[79:64], text_offset[95:80]
    input  logic [95:0] s_axis_tdata,
    // carries_record[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], record_index[16:1], is_utf16[17], text_start[34:18],
    // text_bytes[50:35], zero pad[55:51]
    output logic [55:0] m_axis_tdata,
    // slot[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int N = fnrs_pkg::NumSlots;

    // Configuration registers
    logic [31:0] table_bytes_reg;
    logic [15:0] table_version_reg;
    logic [15:0] record_count_reg;
    logic [15:0] string_base_reg;

    // Run state
    fnrs_pkg::rank_t [N-1:0] rank_reg, rank_next;
    logic [15:0] rec_reg    [N];
    logic [15:0] offset_reg [N];
    logic [15:0] length_reg [N];
    logic [15:0] counter_reg, counter_next;

    // Result bank
    fnrs_pkg::result_t bank_reg [N];
    logic              busy_reg;
    logic [1:0]        drain_reg;

    fnrs_pkg::rec_update_t update;
    logic        s_beat;
    logic        m_beat;
    logic        drain_done;
    logic        rec_take;
    logic        capture;
    logic        header_good;
    logic [19:0] dir_end;
    fnrs_pkg::result_t sel;

    // Latch configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_bytes_reg   <= '0;
            table_version_reg <= '0;
            record_count_reg  <= '0;
            string_base_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                fnrs_pkg::REG_TABLE_BYTES:   table_bytes_reg   <= cfg_wdata;
                fnrs_pkg::REG_TABLE_VERSION: table_version_reg <= cfg_wdata[15:0];
                fnrs_pkg::REG_RECORD_COUNT:  record_count_reg  <= cfg_wdata[15:0];
                fnrs_pkg::REG_STRING_BASE:   string_base_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Handshakes; a last beat waits for a free result bank
    assign m_beat        = m_axis_tvalid && m_axis_tready;
    assign drain_done    = m_beat && (drain_reg == 2'(N - 1));
    assign s_axis_tready = !busy_reg || !s_axis_tlast || drain_done;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    fnrs_record_eval u_eval
    (
        .plat_code    (s_axis_tdata[15:0]),
        .enc_code     (s_axis_tdata[31:16]),
        .lang_code    (s_axis_tdata[47:32]),
        .name_kind    (s_axis_tdata[63:48]),
        .text_length  (s_axis_tdata[79:64]),
        .text_offset  (s_axis_tdata[95:80]),
        .record_idx   (counter_reg),
        .record_count (record_count_reg),
        .string_base  (string_base_reg),
        .table_bytes  (table_bytes_reg),
        .slot_rank    (rank_reg),
        .update       (update)
    );

    assign rec_take = s_beat && s_axis_tuser && update.take;
    assign capture  = s_beat && s_axis_tlast;

    // Header check: 6 + 12 * record_count must fit before string storage
    assign dir_end = fnrs_pkg::HEADER_BYTES + {1'b0, record_count_reg, 3'b000}
                   + {2'b00, record_count_reg, 2'b00};
    assign header_good = (table_bytes_reg >= fnrs_pkg::MIN_TABLE)
                      && (table_version_reg == 16'd0)
                      && ({16'd0, string_base_reg} < table_bytes_reg)
                      && (dir_end <= {4'd0, string_base_reg});

    // Advance the slot ranks and the record counter
    always_comb
    begin
        rank_next    = rank_reg;
        counter_next = counter_reg;
        if (s_beat && s_axis_tuser && counter_reg != 16'hffff)
            counter_next = counter_reg + 16'd1;
        if (rec_take)
            rank_next[update.slot] = update.rank;
        if (capture)
        begin
            rank_next    = '0;
            counter_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg    <= '0;
            counter_reg <= '0;
        end
        else
        begin
            rank_reg    <= rank_next;
            counter_reg <= counter_next;
        end
    end

    // Hold the chosen record of each slot
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            rec_reg[update.slot]    <= counter_reg;
            offset_reg[update.slot] <= s_axis_tdata[95:80];
            length_reg[update.slot] <= s_axis_tdata[79:64];
        end
    end

    // Capture the four results, including a record on the last beat
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int k = 0; k < N; k++)
            begin
                logic            hit;
                logic            fresh;
                fnrs_pkg::rank_t rk;
                logic [15:0]     ri;
                logic [15:0]     ro;
                logic [15:0]     rl;
                fresh = rec_take && (update.slot == 2'(k));
                rk = fresh ? update.rank          : rank_reg[k];
                ri = fresh ? counter_reg         : rec_reg[k];
                ro = fresh ? s_axis_tdata[95:80] : offset_reg[k];
                rl = fresh ? s_axis_tdata[79:64] : length_reg[k];
                hit = header_good && (rk != fnrs_pkg::RANK_NONE);
                bank_reg[k].found        <= hit;
                bank_reg[k].record_index <= hit ? ri : 16'd0;
                bank_reg[k].is_utf16     <= hit && (rk != fnrs_pkg::RANK_ROMAN);
                bank_reg[k].text_start   <= hit ? ({1'b0, string_base_reg} + {1'b0, ro})
                                                : 17'd0;
                bank_reg[k].text_bytes   <= hit ? rl : 16'd0;
            end
        end
    end

    // Drain the bank one beat per slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            drain_reg <= '0;
        end
        else if (capture)
        begin
            busy_reg  <= 1'b1;
            drain_reg <= '0;
        end
        else if (m_beat)
        begin
            drain_reg <= drain_reg + 2'd1;
            if (drain_done)
                busy_reg <= 1'b0;
        end
    end

    // Drive the result beat
    assign sel           = bank_reg[drain_reg];
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tuser  = drain_reg;
    assign m_axis_tlast  = (drain_reg == 2'(N - 1));
    assign m_axis_tdata  = {5'd0, sel.text_bytes, sel.text_start, sel.is_utf16,
                            sel.record_index, sel.found};

endmodule
